>>> hw/rtl/tfvn_pkg.sv
package tfvn_pkg;

  localparam int SIZE_LOG2_DEF   = 9;
  localparam int MAX_OCTAVES_DEF = 8;

  // register indexes on the config port
  localparam logic [1:0] REG_BASE_FREQ    = 2'd0;
  localparam logic [1:0] REG_OCTAVE_COUNT = 2'd1;
  localparam logic [1:0] REG_NOISE_SEED   = 2'd2;

  localparam logic [8:0]  BASE_FREQ_RST    = 9'd16;
  localparam logic [3:0]  OCTAVE_COUNT_RST = 4'd5;
  localparam logic [31:0] NOISE_SEED_RST   = 32'd7;

  // lattice hash
  localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y    = 32'd668265263;
  localparam logic [31:0] HASH_MUL_SEED = 32'd2246822519;
  localparam logic [31:0] HASH_MUL_MIX  = 32'd1274126177;
  localparam int          SEED_STEP     = 101;

  // register stages inside one octave lane
  localparam int LANE_LAT = 7;
  // quotient bits, one divider stage each
  localparam int QUOT_W   = 16;

  typedef struct packed {
    logic [17:0] prod_x;   // wrapped pixel x times base frequency
    logic [17:0] prod_y;
    logic [8:0]  freq;     // effective base frequency
    logic [31:0] seed;
  } lane_in_t;

endpackage

>>> hw/rtl/tileable_fractal_value_noise.sv
// Tileable fractal value noise. Each in_ beat carries one pixel coordinate of a
// square tile 2^SIZE_LOG2 pixels wide; each out_ beat returns one 16-bit noise
// value (Q0.16), in order. Fully pipelined: one pixel per cycle sustained while
// finished values are taken. The pipe is 1 + LANE_LAT + 2 + 16 = 26 register
// stages deep: the coordinate multiply, the seven-stage octave lane (hash
// multiplies, smoothstep, two blends), a two-stage octave sum and the
// sixteen-stage divider that normalizes by 2^K-1. All octaves run as parallel
// lanes, MAX_OCTAVES of them. The whole pipe stalls together when a finished
// value is not taken. Configuration (base_freq, octave_count, noise_seed) is
// to be written through cfg_ only while the pipe is empty; the block itself
// does not enforce it. base_freq 0 acts as 1, octave_count 0 acts as 1 and
// values above MAX_OCTAVES clamp.
module tileable_fractal_value_noise #(
  parameter int SIZE_LOG2   = tfvn_pkg::SIZE_LOG2_DEF,
  parameter int MAX_OCTAVES = tfvn_pkg::MAX_OCTAVES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [8:0]  in_pixel_x,
  input  logic [8:0]  in_pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_noise_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int KW    = $clog2(MAX_OCTAVES + 1);
  localparam int SW    = 16 + MAX_OCTAVES;
  localparam int NG    = (MAX_OCTAVES + 3) / 4;
  localparam int DEPTH = 1 + tfvn_pkg::LANE_LAT + 2 + tfvn_pkg::QUOT_W;
  // pixel wrap: coordinate modulo the tile size
  localparam logic [8:0] PX_MASK = (SIZE_LOG2 >= 9) ? 9'h1FF : 9'((1 << SIZE_LOG2) - 1);

  // config registers
  logic [8:0]  base_freq_r;
  logic [3:0]  octave_count_r;
  logic [31:0] noise_seed_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_freq_r    <= tfvn_pkg::BASE_FREQ_RST;
      octave_count_r <= tfvn_pkg::OCTAVE_COUNT_RST;
      noise_seed_r   <= tfvn_pkg::NOISE_SEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tfvn_pkg::REG_BASE_FREQ:    base_freq_r    <= cfg_data[8:0];
        tfvn_pkg::REG_OCTAVE_COUNT: octave_count_r <= cfg_data[3:0];
        tfvn_pkg::REG_NOISE_SEED:   noise_seed_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective settings
  logic [8:0]    freq_eff;
  logic [KW-1:0] k_eff;
  logic [MAX_OCTAVES-1:0] divisor;

  always_comb begin
    freq_eff = (base_freq_r == 9'd0) ? 9'd1 : base_freq_r;
    if (octave_count_r == 4'd0) begin
      k_eff = KW'(1);
    end else if (32'(octave_count_r) > 32'(MAX_OCTAVES)) begin
      k_eff = KW'(MAX_OCTAVES);
    end else begin
      k_eff = KW'(octave_count_r);
    end
    divisor = MAX_OCTAVES'((SW'(1) << k_eff) - SW'(1));
  end

  // global advance: the pipe moves unless a result is waiting
  logic en;
  logic [DEPTH-1:0] vld_r;

  assign en        = out_ready || !vld_r[DEPTH-1];
  assign in_ready  = en;
  assign out_valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // stage 0: wrapped coordinate times base frequency
  logic [17:0] prod_x_r, prod_y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r <= 18'(in_pixel_x & PX_MASK) * 18'(freq_eff);
      prod_y_r <= 18'(in_pixel_y & PX_MASK) * 18'(freq_eff);
    end
  end

  tfvn_pkg::lane_in_t lane_in;

  assign lane_in = '{prod_x: prod_x_r, prod_y: prod_y_r, freq: freq_eff,
                     seed: noise_seed_r};

  // octave lanes and their weighted terms
  logic [15:0]   lane_n [MAX_OCTAVES];
  logic [SW-1:0] term   [NG*4];

  for (genvar g = 0; g < NG * 4; g++) begin : g_lane
    if (g < MAX_OCTAVES) begin : g_used
      tfvn_octave #(
        .SIZE_LOG2 (SIZE_LOG2),
        .OCT       (g)
      ) u_octave (
        .clk     (clk),
        .en      (en),
        .lane_in (lane_in),
        .noise_o (lane_n[g])
      );
      // octave o weighs 2^(K-1-o) in the sum
      assign term[g] = (KW'(g) < k_eff) ?
                       (SW'(lane_n[g]) << (k_eff - KW'(g) - KW'(1))) : '0;
    end else begin : g_pad
      assign term[g] = '0;
    end
  end

  // octave sum: groups of four, then the groups
  logic [SW-1:0] grp_r [NG];
  logic [SW-1:0] sum_nxt, sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NG; j++) begin
        grp_r[j] <= term[4*j] + term[4*j+1] + term[4*j+2] + term[4*j+3];
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < NG; j++) sum_nxt = sum_nxt + grp_r[j];
  end

  always_ff @(posedge clk) begin
    if (en) sum_r <= sum_nxt;
  end

  // normalize by 2^K-1; sum < 2^16 * divisor, so the quotient fits in 16 bits
  tfvn_div #(
    .SW (SW),
    .DW (MAX_OCTAVES)
  ) u_div (
    .clk      (clk),
    .en       (en),
    .dividend (sum_r),
    .divisor  (divisor),
    .quot     (out_noise_value)
  );

`ifndef SYNTHESIS
  // a stalled pipe keeps every valid bit in place
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid pipe moved during stall");

  // an accepted beat enters stage 0
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted beat lost at entry");

  // normalizing divisor is never zero
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    divisor != '0)
    else $error("zero octave divisor");
`endif

endmodule

>>> hw/rtl/tfvn_octave.sv
module tfvn_octave #(
  parameter int SIZE_LOG2 = tfvn_pkg::SIZE_LOG2_DEF,
  parameter int OCT       = 0
) (
  input  logic               clk,
  input  logic               en,
  input  tfvn_pkg::lane_in_t lane_in,
  output logic [15:0]        noise_o
);

  localparam int QW = 18 + OCT;
  localparam int XW = QW - SIZE_LOG2;
  localparam int FW = 10 + OCT;
  localparam logic [31:0] SEED_OFS = 32'(OCT * tfvn_pkg::SEED_STEP);
  localparam logic [17:0] THREE_Q16 = 18'(3 * 65536);

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] s);
    logic signed [16:0] diff;
    logic signed [33:0] pr;
    logic [17:0]        res;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    pr   = diff * $signed({1'b0, s});
    res  = {2'b00, a} + pr[33:16];
    return res[15:0];
  endfunction

  // stage 1: lattice cells and fractions
  logic [QW-1:0] qx, qy;
  logic [FW-1:0] freq_w, x0p, y0p;
  logic [31:0]   x0_r, x1_r, y0_r, y1_r, sd_r;
  logic [15:0]   fx_r, fy_r;

  always_comb begin
    qx     = QW'(lane_in.prod_x) << OCT;
    qy     = QW'(lane_in.prod_y) << OCT;
    freq_w = FW'(lane_in.freq) << OCT;
    x0p    = FW'(qx[QW-1:SIZE_LOG2]) + FW'(1);
    y0p    = FW'(qy[QW-1:SIZE_LOG2]) + FW'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= 32'(qx[QW-1:SIZE_LOG2]);
      y0_r <= 32'(qy[QW-1:SIZE_LOG2]);
      x1_r <= (x0p == freq_w) ? 32'd0 : 32'(x0p);
      y1_r <= (y0p == freq_w) ? 32'd0 : 32'(y0p);
      fx_r <= 16'(qx[SIZE_LOG2-1:0]) << (16 - SIZE_LOG2);
      fy_r <= 16'(qy[SIZE_LOG2-1:0]) << (16 - SIZE_LOG2);
      sd_r <= lane_in.seed + SEED_OFS;
    end
  end

  // stage 2: hash products, fraction squares
  logic [31:0] mx0_r, mx1_r, my0_r, my1_r, ms_r, fxx_r, fyy_r;
  logic [17:0] tx_r, ty_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mx0_r <= x0_r * tfvn_pkg::HASH_MUL_X;
      mx1_r <= x1_r * tfvn_pkg::HASH_MUL_X;
      my0_r <= y0_r * tfvn_pkg::HASH_MUL_Y;
      my1_r <= y1_r * tfvn_pkg::HASH_MUL_Y;
      ms_r  <= sd_r * tfvn_pkg::HASH_MUL_SEED;
      fxx_r <= {16'd0, fx_r} * {16'd0, fx_r};
      fyy_r <= {16'd0, fy_r} * {16'd0, fy_r};
      tx_r  <= THREE_Q16 - {1'b0, fx_r, 1'b0};
      ty_r  <= THREE_Q16 - {1'b0, fy_r, 1'b0};
    end
  end

  // stage 3: hash sums and first xor-shift, smoothstep
  logic [31:0] h_w [4];
  logic [31:0] g_r [4];
  logic [49:0] sxp, syp;
  logic [15:0] sx3_r, sy3_r;

  always_comb begin
    h_w[0] = mx0_r + my0_r + ms_r;
    h_w[1] = mx1_r + my0_r + ms_r;
    h_w[2] = mx0_r + my1_r + ms_r;
    h_w[3] = mx1_r + my1_r + ms_r;
    sxp    = 50'(fxx_r) * 50'(tx_r);
    syp    = 50'(fyy_r) * 50'(ty_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) g_r[i] <= h_w[i] ^ (h_w[i] >> 13);
      sx3_r <= sxp[47:32];
      sy3_r <= syp[47:32];
    end
  end

  // stage 4: mix multiply
  logic [31:0] m_r [4];
  logic [15:0] sx4_r, sy4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) m_r[i] <= g_r[i] * tfvn_pkg::HASH_MUL_MIX;
      sx4_r <= sx3_r;
      sy4_r <= sy3_r;
    end
  end

  // stage 5: corner values
  logic [31:0] mm_w [4];
  logic [15:0] v_r [4];
  logic [15:0] sx5_r, sy5_r;

  always_comb begin
    for (int i = 0; i < 4; i++) mm_w[i] = m_r[i] ^ (m_r[i] >> 16);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) v_r[i] <= mm_w[i][23:8];
      sx5_r <= sx4_r;
      sy5_r <= sy4_r;
    end
  end

  // stage 6: blend along x; stage 7: along y
  logic [15:0] top_r, bot_r, sy6_r, n_r;

  always_ff @(posedge clk) begin
    if (en) begin
      top_r <= blend(v_r[0], v_r[1], sx5_r);
      bot_r <= blend(v_r[2], v_r[3], sx5_r);
      sy6_r <= sy5_r;
      n_r   <= blend(top_r, bot_r, sy6_r);
    end
  end

  assign noise_o = n_r;

endmodule

>>> hw/rtl/tfvn_div.sv
module tfvn_div #(
  parameter int SW = 24,
  parameter int DW = 8
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [SW-1:0]               dividend,
  input  logic [DW-1:0]               divisor,
  output logic [tfvn_pkg::QUOT_W-1:0] quot
);

  localparam int QB = tfvn_pkg::QUOT_W;
  localparam int RW = SW + QB;

  logic [SW-1:0] rem_r [QB];
  logic [QB-1:0] q_r   [QB];

  // restoring division, one quotient bit per stage, msb first;
  // quotient is known to fit in QB bits
  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [SW-1:0] rin;
    logic [QB-1:0] qin;
    logic [RW-1:0] sh;
    logic          take;
    if (i == 0) begin : g_first
      assign rin = dividend;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[i-1];
      assign qin = q_r[i-1];
    end
    assign sh   = RW'(divisor) << (QB - 1 - i);
    assign take = RW'(rin) >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= take ? SW'(RW'(rin) - sh) : rin;
        q_r[i]   <= qin | (take ? (QB'(1) << (QB - 1 - i)) : '0);
      end
    end
  end

  assign quot = q_r[QB-1];

endmodule
